// ===== hw/rtl/mspg_pkg.sv =====
// ----------------------------------------------------------------------------
// mspg_pkg
// Types, codes and default sizes for the sustain-pedal emulator with its
// pulse gate.
// ----------------------------------------------------------------------------
package mspg_pkg;

  // Default sizes of the note store.
  localparam int CHANNELS_DEF  = 16;
  localparam int KEYS_DEF      = 128;
  localparam int BANK_SIZE_DEF = 64;

  // Field widths of one request and one result.
  localparam int KIND_W  = 3;
  localparam int CHAN_W  = 4;
  localparam int KEY_W   = 7;
  localparam int AMT_W   = 7;
  localparam int OKIND_W = 2;

  // Sustain pedal controller and the value from which it counts as pressed.
  localparam logic [KEY_W-1:0] PEDAL_CC     = 7'd64;
  localparam logic [AMT_W-1:0] PEDAL_ON_MIN = 7'd64;

  // Input request kinds.
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_ON   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CC        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PULSE_ON  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PULSE_OFF = 3'd4;

  // Result kinds.
  localparam logic [OKIND_W-1:0] OUT_NOTE_ON  = 2'd0;
  localparam logic [OKIND_W-1:0] OUT_NOTE_OFF = 2'd1;
  localparam logic [OKIND_W-1:0] OUT_CC       = 2'd2;

  // Per-note mode; the fourth code is never written and reads as off.
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SUST = 2'd2
  } mode_t;

  // One word of the note store.
  typedef struct packed {
    mode_t             mode;
    logic [AMT_W-1:0]  vel;
  } entry_t;

  // One result message.
  typedef struct packed {
    logic [OKIND_W-1:0] kind;
    logic [CHAN_W-1:0]  chan;
    logic [KEY_W-1:0]   key;
    logic [AMT_W-1:0]   amount;
  } res_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_NOTE,
    S_NOTE_ON2,
    S_WALK,
    S_FLUSH
  } state_t;

endpackage

// ===== hw/rtl/midi_sustain_pulse_gate.sv =====
// ----------------------------------------------------------------------------
// midi_sustain_pulse_gate
// Sustain-pedal emulator with a pulse gate over decoded MIDI events.
// ----------------------------------------------------------------------------
// Requests enter on the in_ channel (valid/ready) and results leave on the
// out_ channel (valid/ready); out_last marks the final result of a request.
// Velocity and mode of every channel and key live in one single-port-write,
// registered-read note store of CHANNELS*KEYS words, driven by a small
// sequencer that visits one word per cycle while no result is stalled.
// A sweep or a sustain release visits one stored note per cycle on the same
// terms. One request is worked on at a time and in_ready is high only between
// requests; a pedal press, an ignored request or an empty bank leave it high.
// After reset the note store is cleared one word per cycle; no request is
// taken meanwhile. Pedal flags and the gate clear at once.
// A result waits in the output register while the receiver stalls, with one
// more held behind it; the sequencer pauses on the next result it makes.
// ----------------------------------------------------------------------------
module midi_sustain_pulse_gate #(
  parameter int CHANNELS  = mspg_pkg::CHANNELS_DEF,
  parameter int KEYS      = mspg_pkg::KEYS_DEF,
  parameter int BANK_SIZE = mspg_pkg::BANK_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mspg_pkg::KIND_W-1:0] in_kind,
  input  logic [mspg_pkg::CHAN_W-1:0] in_chan,
  input  logic [mspg_pkg::KEY_W-1:0]  in_key,
  input  logic [mspg_pkg::AMT_W-1:0]  in_amount,
  input  logic                        in_bank,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mspg_pkg::OKIND_W-1:0] out_kind,
  output logic [mspg_pkg::CHAN_W-1:0]  out_chan,
  output logic [mspg_pkg::KEY_W-1:0]   out_key,
  output logic [mspg_pkg::AMT_W-1:0]   out_amount,
  output logic                         out_last
);

  localparam int DEPTH  = CHANNELS * KEYS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W  = $clog2(BANK_SIZE);
  localparam int KW     = mspg_pkg::KEY_W;

  // Sequencer and item registers.
  mspg_pkg::state_t            state_r, state_nxt;
  logic [ADDR_W-1:0]           addr_r, addr_nxt;
  logic [KW-1:0]               note_r, note_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [mspg_pkg::KIND_W-1:0] kind_r;
  logic [mspg_pkg::CHAN_W-1:0] chan_r;
  logic [mspg_pkg::AMT_W-1:0]  amount_r;
  logic                        gate_r;
  logic [CHANNELS-1:0]         pedal_r;

  // Holding and output registers.
  mspg_pkg::res_t hold_r, out_r;
  logic           hold_valid_r, out_valid_r, out_last_r;

  // Note store.
  mspg_pkg::entry_t mem [DEPTH];
  mspg_pkg::entry_t rd_r, wr_data;
  logic             wr_en, want_wr;

  // Result path control.
  mspg_pkg::res_t push_data;
  logic           push_req, push_fire, can_push, out_free, step_go;
  logic           move_hold, flush_move;

  // Request decode.
  logic          in_acc, chan_ok, key_ok, base_ok;
  logic          is_note, acc_note, acc_cc, acc_fwd, acc_press, acc_release;
  logic          acc_sweep, acc_walk;
  logic [KW-1:0] bank_base, start_note;
  logic [ADDR_W-1:0] start_addr;
  logic          note_off_path, held, pedal_cur, walk_last, clear_last;

  // ---------------------------------------------------------------------------
  // Request decode at acceptance.
  // ---------------------------------------------------------------------------
  assign in_ready = (state_r == mspg_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign chan_ok = {1'b0, in_chan} < (mspg_pkg::CHAN_W+1)'(CHANNELS);
  assign key_ok  = {1'b0, in_key} < (KW+1)'(KEYS);
  assign is_note = (in_kind == mspg_pkg::KIND_NOTE_OFF) ||
                   (in_kind == mspg_pkg::KIND_NOTE_ON);

  assign acc_note    = chan_ok && is_note && key_ok;
  assign acc_cc      = chan_ok && (in_kind == mspg_pkg::KIND_CC);
  assign acc_fwd     = acc_cc && (in_key != mspg_pkg::PEDAL_CC);
  assign acc_press   = acc_cc && (in_key == mspg_pkg::PEDAL_CC) &&
                       (in_amount >= mspg_pkg::PEDAL_ON_MIN);
  assign acc_release = acc_cc && (in_key == mspg_pkg::PEDAL_CC) &&
                       (in_amount < mspg_pkg::PEDAL_ON_MIN);
  assign acc_sweep   = chan_ok && ((in_kind == mspg_pkg::KIND_PULSE_ON) ||
                                   (in_kind == mspg_pkg::KIND_PULSE_OFF));

  // A bank walk starts at the bank's first note and is empty past the keys.
  assign bank_base  = in_bank ? KW'(BANK_SIZE) : '0;
  assign base_ok    = {1'b0, bank_base} < (KW+1)'(KEYS);
  assign acc_walk   = (acc_release || acc_sweep) && base_ok;
  assign start_note = acc_note ? in_key : bank_base;
  assign start_addr = ADDR_W'(int'(in_chan) * KEYS + int'(start_note));

  // ---------------------------------------------------------------------------
  // Conditions on the current word.
  // ---------------------------------------------------------------------------
  assign note_off_path = (kind_r == mspg_pkg::KIND_NOTE_OFF) || (amount_r == '0);
  assign held          = (rd_r.vel != '0);
  assign pedal_cur     = pedal_r[chan_r[CH_W-1:0]];
  assign walk_last     = (idx_r == IDX_W'(BANK_SIZE - 1)) ||
                         (({1'b0, note_r} + (KW+1)'(1)) >= (KW+1)'(KEYS));
  assign clear_last    = (addr_r == ADDR_W'(DEPTH - 1));

  // A new result may enter the holding register when it is empty or when
  // its content can move on to the output register.
  assign out_free   = !out_valid_r || out_ready;
  assign can_push   = !hold_valid_r || out_free;
  assign step_go    = !push_req || can_push;
  assign push_fire  = push_req && can_push;
  assign flush_move = (state_r == mspg_pkg::S_FLUSH) && hold_valid_r && out_free;
  assign move_hold  = (push_fire && hold_valid_r) || flush_move;
  assign wr_en      = want_wr && step_go;

  // ---------------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mspg_pkg::S_CLEAR: begin
        if (clear_last) state_nxt = mspg_pkg::S_IDLE;
      end
      mspg_pkg::S_IDLE: begin
        if (in_acc) begin
          priority if (acc_note) state_nxt = mspg_pkg::S_NOTE;
          else if (acc_fwd)      state_nxt = mspg_pkg::S_FLUSH;
          else if (acc_walk)     state_nxt = mspg_pkg::S_WALK;
          else                   state_nxt = mspg_pkg::S_IDLE;
        end
      end
      mspg_pkg::S_NOTE: begin
        if (step_go) begin
          if (!note_off_path && gate_r) state_nxt = mspg_pkg::S_NOTE_ON2;
          else                          state_nxt = mspg_pkg::S_FLUSH;
        end
      end
      mspg_pkg::S_NOTE_ON2: begin
        if (can_push) state_nxt = mspg_pkg::S_FLUSH;
      end
      mspg_pkg::S_WALK: begin
        if (step_go && walk_last) state_nxt = mspg_pkg::S_FLUSH;
      end
      mspg_pkg::S_FLUSH: begin
        if (!hold_valid_r || out_free) state_nxt = mspg_pkg::S_IDLE;
      end
      default: state_nxt = mspg_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath control: store writes, results and the walk address.
  // The store is read at the next address, so the read register holds the current word.
  // ---------------------------------------------------------------------------
  always_comb begin
    push_req  = 1'b0;
    push_data = '0;
    want_wr   = 1'b0;
    wr_data   = '0;
    addr_nxt  = addr_r;
    note_nxt  = note_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      mspg_pkg::S_CLEAR: begin
        want_wr  = 1'b1;
        addr_nxt = addr_r + ADDR_W'(1);
      end
      mspg_pkg::S_IDLE: begin
        if (in_acc) begin
          addr_nxt = start_addr;
          note_nxt = start_note;
          idx_nxt  = '0;
          if (acc_fwd) begin
            push_req  = 1'b1;
            push_data = '{kind: mspg_pkg::OUT_CC, chan: in_chan, key: in_key,
                          amount: in_amount};
          end
        end
      end
      mspg_pkg::S_NOTE: begin
        push_data = '{kind: mspg_pkg::OUT_NOTE_OFF, chan: chan_r, key: note_r,
                      amount: '0};
        if (note_off_path) begin
          // Note off acts only on a playing note; a pressed pedal sustains it.
          if (rd_r.mode == mspg_pkg::MODE_ON) begin
            want_wr = 1'b1;
            if (pedal_cur) begin
              wr_data = '{mode: mspg_pkg::MODE_SUST, vel: rd_r.vel};
            end else begin
              push_req = gate_r && held;
              wr_data  = '{mode: mspg_pkg::MODE_OFF, vel: '0};
            end
          end
        end else begin
          // Note on silences whatever is held before the new velocity while the gate is open.
          push_req = gate_r && held;
          want_wr  = 1'b1;
          wr_data  = '{mode: mspg_pkg::MODE_ON, vel: amount_r};
        end
      end
      mspg_pkg::S_NOTE_ON2: begin
        push_req  = 1'b1;
        push_data = '{kind: mspg_pkg::OUT_NOTE_ON, chan: chan_r, key: note_r,
                      amount: amount_r};
      end
      mspg_pkg::S_WALK: begin
        if (kind_r == mspg_pkg::KIND_CC) begin
          // Sustain release: every sustained note of the bank goes off.
          push_data = '{kind: mspg_pkg::OUT_NOTE_OFF, chan: chan_r, key: note_r,
                        amount: '0};
          if (rd_r.mode == mspg_pkg::MODE_SUST) begin
            want_wr  = 1'b1;
            wr_data  = '{mode: mspg_pkg::MODE_OFF, vel: '0};
            push_req = gate_r && held;
          end
        end else if (kind_r == mspg_pkg::KIND_PULSE_ON) begin
          push_req  = held;
          push_data = '{kind: mspg_pkg::OUT_NOTE_ON, chan: chan_r, key: note_r,
                        amount: rd_r.vel};
        end else begin
          push_req  = held;
          push_data = '{kind: mspg_pkg::OUT_NOTE_OFF, chan: chan_r, key: note_r,
                        amount: '0};
        end
        if ((!push_req || can_push) && !walk_last) begin
          addr_nxt = addr_r + ADDR_W'(1);
          note_nxt = note_r + KW'(1);
          idx_nxt  = idx_r + IDX_W'(1);
        end
      end
      mspg_pkg::S_FLUSH: begin
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Note store: one write and one registered read per cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_r] <= wr_data;
    end
    rd_r <= mem[addr_nxt];
  end

  // ---------------------------------------------------------------------------
  // Sequencer, pedal flags and gate.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mspg_pkg::S_CLEAR;
      addr_r  <= '0;
      gate_r  <= 1'b0;
      pedal_r <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      // A walk never reads the pedal flag and a sweep never reads the gate, so
      // they change as the request is taken.
      if (in_acc && acc_sweep) begin
        gate_r <= (in_kind == mspg_pkg::KIND_PULSE_ON);
      end
      if (in_acc && acc_press) begin
        pedal_r[in_chan[CH_W-1:0]] <= 1'b1;
      end
      if (in_acc && acc_release && in_bank) begin
        pedal_r[in_chan[CH_W-1:0]] <= 1'b0;
      end
    end
  end

  // Item fields and walk position.
  always_ff @(posedge clk) begin
    note_r <= note_nxt;
    idx_r  <= idx_nxt;
    if (in_acc) begin
      kind_r   <= in_kind;
      chan_r   <= in_chan;
      amount_r <= in_amount;
    end
  end

  // ---------------------------------------------------------------------------
  // Holding register: the newest result waits here until the next one or the
  // end of the request shows whether it is the last.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (push_fire) begin
      hold_valid_r <= 1'b1;
    end else if (flush_move) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      hold_r <= push_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move_hold) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_hold) begin
      out_r      <= hold_r;
      out_last_r <= flush_move;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_r.kind;
  assign out_chan   = out_r.chan;
  assign out_key    = out_r.key;
  assign out_amount = out_r.amount;
  assign out_last   = out_last_r;

endmodule

// ===== bench/midi_sustain_pulse_gate_checker.sv =====
// ----------------------------------------------------------------------------
// midi_sustain_pulse_gate_checker
// Watches both channels of the sustain-pedal emulator, keeps its own copy of
// the note store, pedal flags and pulse gate, works out the messages each
// accepted request must cause and compares every accepted result, field by
// field, against the oldest message still awaited.
// ----------------------------------------------------------------------------
module midi_sustain_pulse_gate_checker
  import mspg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [CHAN_W-1:0]  in_chan,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [AMT_W-1:0]   in_amount,
  input  logic               in_bank,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [OKIND_W-1:0] out_kind,
  input  logic [CHAN_W-1:0]  out_chan,
  input  logic [KEY_W-1:0]   out_key,
  input  logic [AMT_W-1:0]   out_amount,
  input  logic               out_last,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = CHANNELS_DEF * KEYS_DEF;

  // One message as it should leave the block.
  typedef struct packed {
    logic [OKIND_W-1:0] kind;
    logic [CHAN_W-1:0]  chan;
    logic [KEY_W-1:0]   key;
    logic [AMT_W-1:0]   amount;
    logic               last;
  } note_msg_t;

  // Shadow copy of the emulator state.
  logic [AMT_W-1:0] vel_store  [STORE_DEPTH];
  mode_t            mode_store [STORE_DEPTH];
  logic             pedal_held [CHANNELS_DEF];
  logic             gate_is_open;

  note_msg_t awaited_msgs[$];
  int        error_count = 0;
  int        awaited_count = 0;

  assign errors  = error_count;
  assign pending = awaited_count;

  function automatic int note_index(int ch, int k);
    return ch * KEYS_DEF + k;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic emit_msg(logic [OKIND_W-1:0] kind, int ch, int k, int amt);
    note_msg_t m;
    m.kind   = kind;
    m.chan   = CHAN_W'(ch);
    m.key    = KEY_W'(k);
    m.amount = AMT_W'(amt);
    m.last   = 1'b0;
    awaited_msgs.push_back(m);
  endtask

  // Drop the held velocity; the note is silenced only while the gate is open.
  task automatic release_note(int ch, int k);
    int idx;
    idx = note_index(ch, k);
    if (gate_is_open && vel_store[idx] != 0) emit_msg(OUT_NOTE_OFF, ch, k, 0);
    vel_store[idx] = '0;
  endtask

  // Work out the messages of one request and update the shadow state.
  task automatic predict_messages(logic [KIND_W-1:0] kind, int ch, int k, int amt,
                                  logic bank);
    int        queued_at_start;
    int        idx;
    int        base;
    int        note;
    note_msg_t tail;
    queued_at_start = awaited_msgs.size();
    idx    = note_index(ch, k);
    base   = bank ? BANK_SIZE_DEF : 0;
    if (ch >= CHANNELS_DEF || kind > KIND_PULSE_OFF) return;
    case (kind)
      KIND_NOTE_OFF, KIND_NOTE_ON: begin
        if (k >= KEYS_DEF) return;
        if (kind == KIND_NOTE_OFF || amt == 0) begin
          // A note off only acts on a sounding note; the pedal holds it on.
          if (mode_store[idx] == MODE_ON) begin
            if (pedal_held[ch]) begin
              mode_store[idx] = MODE_SUST;
            end else begin
              release_note(ch, k);
              mode_store[idx] = MODE_OFF;
            end
          end
        end else begin
          if (mode_store[idx] == MODE_ON || mode_store[idx] == MODE_SUST) begin
            release_note(ch, k);
          end
          if (gate_is_open) begin
            if (vel_store[idx] != 0) emit_msg(OUT_NOTE_OFF, ch, k, 0);
            emit_msg(OUT_NOTE_ON, ch, k, amt);
          end
          vel_store[idx]  = AMT_W'(amt);
          mode_store[idx] = MODE_ON;
        end
      end
      KIND_CC: begin
        if (k == PEDAL_CC) begin
          if (amt >= PEDAL_ON_MIN) begin
            pedal_held[ch] = 1'b1;
          end else begin
            // A release frees the sustained notes of one bank only.
            for (int i = 0; i < BANK_SIZE_DEF; i++) begin
              note = base + i;
              if (note >= KEYS_DEF) break;
              if (mode_store[note_index(ch, note)] == MODE_SUST) begin
                release_note(ch, note);
                mode_store[note_index(ch, note)] = MODE_OFF;
              end
            end
            if (bank) pedal_held[ch] = 1'b0;
          end
        end else begin
          emit_msg(OUT_CC, ch, k, amt);
        end
      end
      default: begin
        // Pulse sweeps re-send or silence every held note of the bank.
        for (int i = 0; i < BANK_SIZE_DEF; i++) begin
          note = base + i;
          if (note >= KEYS_DEF) break;
          if (vel_store[note_index(ch, note)] != 0) begin
            if (kind == KIND_PULSE_ON) begin
              emit_msg(OUT_NOTE_ON, ch, note, vel_store[note_index(ch, note)]);
            end else begin
              emit_msg(OUT_NOTE_OFF, ch, note, 0);
            end
          end
        end
        gate_is_open = (kind == KIND_PULSE_ON);
      end
    endcase
    if (awaited_msgs.size() > queued_at_start) begin
      tail = awaited_msgs.pop_back();
      tail.last = 1'b1;
      awaited_msgs.push_back(tail);
    end
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic check_result();
    note_msg_t want;
    if (awaited_msgs.size() == 0) begin
      report_mismatch($sformatf("result with nothing awaited: kind %0d chan %0d key %0d amount %0d",
                                out_kind, out_chan, out_key, out_amount));
      return;
    end
    want = awaited_msgs.pop_front();
    compare_field("kind", 8'(out_kind), 8'(want.kind));
    compare_field("chan", 8'(out_chan), 8'(want.chan));
    compare_field("key", 8'(out_key), 8'(want.key));
    compare_field("amount", 8'(out_amount), 8'(want.amount));
    compare_field("last", 8'(out_last), 8'(want.last));
  endtask

  // Requests are taken before results at the same edge; a result can never
  // belong to a request accepted at that very edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        vel_store[i]  = '0;
        mode_store[i] = MODE_OFF;
      end
      for (int c = 0; c < CHANNELS_DEF; c++) pedal_held[c] = 1'b0;
      gate_is_open = 1'b0;
      awaited_msgs.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_messages(in_kind, in_chan, in_key, in_amount, in_bank);
      end
      if (out_valid && out_ready) check_result();
    end
    awaited_count <= awaited_msgs.size();
  end

endmodule

// ===== bench/midi_sustain_pulse_gate_tb.sv =====
// ----------------------------------------------------------------------------
// midi_sustain_pulse_gate_tb
// Drives decoded MIDI requests into the sustain-pedal emulator: a directed
// opening over the pedal, the pulse gate and the corner notes, then weighted
// random traffic on a few busy channels, with idle bursts on both sides.
// The checker beside the block predicts and compares; this top gives the
// verdict.
// ----------------------------------------------------------------------------
module midi_sustain_pulse_gate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mspg_pkg::*;

  localparam int RANDOM_ITEMS = 405;
  localparam int CALM_ITEMS   = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind = '0;
  logic [CHAN_W-1:0]  in_chan = '0;
  logic [KEY_W-1:0]   in_key = '0;
  logic [AMT_W-1:0]   in_amount = '0;
  logic               in_bank = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [OKIND_W-1:0] out_kind;
  logic [CHAN_W-1:0]  out_chan;
  logic [KEY_W-1:0]   out_key;
  logic [AMT_W-1:0]   out_amount;
  logic               out_last;

  int   check_errors;
  int   check_pending;
  logic gaps_on = 1'b1;
  int   stall_left = 0;
  int   items_sent = 0;
  logic mid_pause_done = 1'b0;

  midi_sustain_pulse_gate u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_chan   (in_chan),
    .in_key    (in_key),
    .in_amount (in_amount),
    .in_bank   (in_bank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_chan  (out_chan),
    .out_key   (out_key),
    .out_amount(out_amount),
    .out_last  (out_last)
  );

  midi_sustain_pulse_gate_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_chan   (in_chan),
    .in_key    (in_key),
    .in_amount (in_amount),
    .in_bank   (in_bank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_chan  (out_chan),
    .out_key   (out_key),
    .out_amount(out_amount),
    .out_last  (out_last),
    .errors    (check_errors),
    .pending   (check_pending)
  );

  always #5 clk = ~clk;

  // The receiver stalls in short bursts while idling is enabled.
  always @(posedge clk) begin
    if (!gaps_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request, after an optional idle burst, and hold it until taken.
  task automatic send_request(logic [KIND_W-1:0] kind, int ch, int k, int amt,
                              logic bank);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_chan   <= CHAN_W'(ch);
    in_key    <= KEY_W'(k);
    in_amount <= AMT_W'(amt);
    in_bank   <= bank;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold back the sender until every awaited result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed traffic on a few channels and a handful of keys per
  // bank, so that notes collide, sustain and get swept; some noise besides.
  task automatic random_request();
    int                r;
    int                ch;
    int                k;
    int                amt;
    logic              bank;
    logic [KIND_W-1:0] kind;
    r    = $urandom_range(0, 99);
    ch   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    bank = 1'($urandom_range(0, 1));
    k    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                       : (bank ? 64 : 0) + $urandom_range(0, 5);
    amt  = $urandom_range(1, 127);
    if (r < 34) begin
      kind = KIND_NOTE_ON;
      if ($urandom_range(0, 9) == 0) amt = 0;
    end else if (r < 56) begin
      kind = KIND_NOTE_OFF;
      amt  = $urandom_range(0, 127);
    end else if (r < 66) begin
      kind = KIND_CC;
      k    = PEDAL_CC;
      amt  = $urandom_range(64, 127);
    end else if (r < 76) begin
      kind = KIND_CC;
      k    = PEDAL_CC;
      amt  = $urandom_range(0, 63);
    end else if (r < 82) begin
      kind = KIND_CC;
      k    = $urandom_range(0, 127);
      amt  = $urandom_range(0, 127);
    end else if (r < 89) begin
      kind = KIND_PULSE_ON;
    end else if (r < 96) begin
      kind = KIND_PULSE_OFF;
    end else if (r < 98) begin
      kind = KIND_W'($urandom_range(0, 7));
      ch   = $urandom_range(0, 15);
      k    = $urandom_range(0, 127);
      amt  = $urandom_range(0, 127);
    end else begin
      kind = KIND_W'($urandom_range(5, 7));
    end
    send_request(kind, ch, k, amt, bank);
    if (kind <= KIND_PULSE_OFF) items_sent++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // A note held while the gate is shut, then opened by a pulse-on sweep.
    send_request(KIND_NOTE_ON, 0, 0, 127, 1'b0);
    send_request(KIND_PULSE_ON, 0, 0, 0, 1'b0);
    // Striking a sounding note again silences it first.
    send_request(KIND_NOTE_ON, 0, 0, 1, 1'b0);
    send_request(KIND_NOTE_ON, 15, 127, 64, 1'b0);
    send_request(KIND_NOTE_OFF, 15, 127, 127, 1'b0);
    // Pedal down: note offs and zero-velocity note ons only sustain.
    send_request(KIND_CC, 0, PEDAL_CC, 127, 1'b0);
    send_request(KIND_NOTE_OFF, 0, 0, 0, 1'b0);
    send_request(KIND_NOTE_ON, 0, 63, 100, 1'b0);
    send_request(KIND_NOTE_ON, 0, 63, 0, 1'b0);
    // Releasing bank 0 frees its notes but leaves the pedal flag set.
    send_request(KIND_CC, 0, PEDAL_CC, 63, 1'b0);
    send_request(KIND_NOTE_ON, 0, 64, 9, 1'b0);
    send_request(KIND_NOTE_OFF, 0, 64, 0, 1'b0);
    // Releasing bank 1 frees its notes and lifts the pedal.
    send_request(KIND_CC, 0, PEDAL_CC, 0, 1'b1);
    send_request(KIND_NOTE_OFF, 0, 64, 0, 1'b0);
    // Other controllers are passed through.
    send_request(KIND_CC, 2, 0, 0, 1'b0);
    send_request(KIND_CC, 14, 127, 127, 1'b1);
    // Striking a sustained note again.
    send_request(KIND_CC, 3, PEDAL_CC, 64, 1'b0);
    send_request(KIND_NOTE_ON, 3, 70, 20, 1'b0);
    send_request(KIND_NOTE_OFF, 3, 70, 0, 1'b0);
    send_request(KIND_NOTE_ON, 3, 70, 30, 1'b0);
    // Sweeps over bank 1, and an empty bank that still closes the gate.
    send_request(KIND_PULSE_OFF, 3, 0, 0, 1'b1);
    send_request(KIND_NOTE_ON, 3, 71, 5, 1'b0);
    send_request(KIND_PULSE_ON, 3, 0, 0, 1'b1);
    send_request(KIND_PULSE_OFF, 15, 0, 0, 1'b0);
    // Unused kinds are ignored.
    for (int i = 5; i <= 7; i++) send_request(KIND_W'(i), 0, 0, 0, 1'b0);
    wait_for_results();

    // Random traffic in stretches with and without idling, calm at the end.
    while (items_sent < RANDOM_ITEMS) begin
      gaps_on <= ((items_sent / 80) % 2 == 0) && (items_sent < RANDOM_ITEMS - CALM_ITEMS);
      if (items_sent >= 200 && !mid_pause_done) begin
        mid_pause_done = 1'b1;
        wait_for_results();
      end
      random_request();
    end

    wait_for_results();
    repeat (80) @(posedge clk);
    if (check_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
